@@ hw/rtl/rirs_pkg.sv @@
// shared constants for the rounded integer square root block
package rirs_pkg;

    localparam int INPUT_BITS_DEF = 31;
    localparam int ROOT_BITS      = 16;
    localparam int STEP_LIMIT     = 256;
    localparam int STEP_BITS      = $clog2(STEP_LIMIT);

endpackage

@@ hw/rtl/rirs_div.sv @@
// restoring serial divider, one quotient bit per cycle
module rirs_div #(
    parameter int QUOT_BITS = 33,
    parameter int DIVR_BITS = 18
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [QUOT_BITS-1:0] dividend,
    input  logic [DIVR_BITS-1:0] divisor,
    output logic                 done,
    output logic [QUOT_BITS-1:0] quotient
);
    import rirs_pkg::*;

    localparam int CNT_BITS = (QUOT_BITS > 1) ? $clog2(QUOT_BITS) : 1;

    logic [DIVR_BITS-1:0] rem_reg, rem_next;
    logic [QUOT_BITS-1:0] quo_reg, quo_next;
    logic [DIVR_BITS-1:0] dvr_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIVR_BITS:0]   trial;
    logic [DIVR_BITS:0]   diff;
    logic                 fits;

    assign trial = {rem_reg, quo_reg[QUOT_BITS-1]};
    assign fits  = trial >= {1'b0, dvr_reg};
    assign diff  = trial - {1'b0, dvr_reg};

    always_comb begin
        rem_next = fits ? diff[DIVR_BITS-1:0] : trial[DIVR_BITS-1:0];
        quo_next = {quo_reg[QUOT_BITS-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(QUOT_BITS - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvr_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ hw/rtl/rounded_integer_square_root.sv @@
// rounded integer square root by newton iteration on four times the input
//
//  channel  | dir | beat payload
//  s_*      | in  | s_tdata: radicand (INPUT_BITS, zero padded to bytes)
//  m_*      | out | m_tdata: root (16 bits)
//
// time per item grows with the number of base-4 digits of the radicand and with the
// number of newton steps, at most STEP_LIMIT; it is set by the single serial divider,
// one quotient bit per cycle
// reset clears the sequencer and the output valid flag
// a finished result waits in the output register, the next beat is taken meanwhile
module rounded_integer_square_root #(
    parameter int INPUT_BITS = rirs_pkg::INPUT_BITS_DEF,
    localparam int S_DATA_BITS = ((INPUT_BITS + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [S_DATA_BITS-1:0]        s_tdata,   // radicand
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rirs_pkg::ROOT_BITS-1:0] m_tdata    // root
);
    import rirs_pkg::*;

    localparam int QUAD_BITS  = INPUT_BITS + 2;
    localparam int GUESS_BITS = (INPUT_BITS + 1) / 2 + 2;
    localparam int EXT_BITS   = (GUESS_BITS > ROOT_BITS) ? GUESS_BITS : ROOT_BITS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]            state_reg;
    logic [INPUT_BITS-1:0] scan_reg;
    logic [GUESS_BITS-1:0] guess_reg;
    logic [QUAD_BITS-1:0]  quad_reg;
    logic [STEP_BITS-1:0]  step_reg;
    logic [ROOT_BITS-1:0]  result_reg;
    logic [ROOT_BITS-1:0]  m_data_reg;
    logic                  m_valid_reg;

    logic                  div_start;
    logic                  div_done;
    logic [QUAD_BITS-1:0]  div_quot;
    logic [GUESS_BITS-1:0] div_guess;
    logic [GUESS_BITS-1:0] div_divisor;
    logic [QUAD_BITS:0]    sum;
    logic [GUESS_BITS-1:0] guess_next;
    logic [GUESS_BITS:0]   round_sum;
    logic [EXT_BITS-1:0]   root_ext;
    logic                  converged;
    logic                  s_fire;
    logic                  out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // a restart from a finished step divides by the new guess
    assign div_guess   = (state_reg == ST_DIV) ? guess_next : guess_reg;
    assign div_divisor = (div_guess == '0) ? GUESS_BITS'(1) : div_guess;
    assign sum         = {1'b0, div_quot} + (QUAD_BITS + 1)'(guess_reg);
    assign guess_next  = sum[GUESS_BITS:1];
    assign converged   = (guess_reg[GUESS_BITS-1:1] == guess_next[GUESS_BITS-1:1]);
    assign round_sum   = {1'b0, guess_next} + (GUESS_BITS + 1)'(1);
    assign root_ext    = EXT_BITS'(round_sum[GUESS_BITS:1]);

    always_comb begin
        div_start = 1'b0;
        unique case (state_reg)
            ST_SCAN: div_start = (scan_reg == '0);
            ST_DIV:  div_start = div_done && !converged
                                 && (step_reg != STEP_BITS'(STEP_LIMIT - 1));
            default: div_start = 1'b0;
        endcase
    end

    rirs_div #(
        .QUOT_BITS (QUAD_BITS),
        .DIVR_BITS (GUESS_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (quad_reg),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (scan_reg == '0) begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_done && !div_start) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            scan_reg  <= s_tdata[INPUT_BITS-1:0];
            guess_reg <= GUESS_BITS'(2);
            quad_reg  <= {s_tdata[INPUT_BITS-1:0], 2'b00};
            step_reg  <= '0;
        end else if (state_reg == ST_SCAN && scan_reg != '0) begin
            scan_reg  <= scan_reg >> 2;
            guess_reg <= guess_reg << 1;
        end else if (state_reg == ST_DIV && div_done) begin
            guess_reg  <= guess_next;
            step_reg   <= step_reg + 1'b1;
            result_reg <= root_ext[ROOT_BITS-1:0];
        end
        if (state_reg == ST_DONE && out_free) begin
            m_data_reg <= result_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

@@ hw/rtl/rirs_checker.sv @@
// port-level checks for the rounded integer square root block
module rirs_checker #(
    parameter int INPUT_BITS = rirs_pkg::INPUT_BITS_DEF,
    localparam int S_DATA_BITS = ((INPUT_BITS + 7) / 8) * 8
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [S_DATA_BITS-1:0]         s_tdata,   // radicand
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [rirs_pkg::ROOT_BITS-1:0] m_tdata    // root
);
    import rirs_pkg::*;

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("input beat dropped or changed while stalled");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat dropped or changed while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
        else $error("input taken again before the root was worked out");

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("block not idle after reset");

endmodule

bind rounded_integer_square_root rirs_checker #(.INPUT_BITS(INPUT_BITS)) u_rirs_checker (.*);
